### rtl/safhm_pkg.sv
package safhm_pkg;

  localparam int FIFO_FRAMES    = 16384;
  localparam int SAMPLE_RATE_HZ = 48000;

  localparam int PTR_W   = $clog2(FIFO_FRAMES);
  localparam int COUNT_W = $clog2(FIFO_FRAMES + 1);
  localparam int HALF_FRAMES = FIFO_FRAMES / 2;

  // latency = count * 1000 / SAMPLE_RATE_HZ via reciprocal
  localparam int LAT_SHIFT = 32;
  localparam longint unsigned LAT_MULT =
    ((longint'(1000) << LAT_SHIFT) + longint'(SAMPLE_RATE_HZ) - 1) / SAMPLE_RATE_HZ;
  localparam int LAT_MULT_W = $clog2(LAT_MULT + 1);

  // target frames = target * FIFO_FRAMES / 100 via reciprocal
  localparam int TF_SHIFT = 24;
  localparam longint unsigned TF_MULT =
    ((longint'(FIFO_FRAMES) << TF_SHIFT) + 99) / 100;
  localparam int TF_MULT_W = $clog2(TF_MULT + 1);

  localparam logic [6:0] TARGET_RESET = 7'd25;
  localparam logic [6:0] TARGET_MIN   = 7'd10;
  localparam logic [6:0] TARGET_MAX   = 7'd70;
  localparam logic [6:0] TARGET_RISE_LIMIT = 7'd60;
  localparam logic [6:0] TARGET_FALL_LIMIT = 7'd15;
  localparam logic [6:0] TARGET_STEP  = 7'd5;
  localparam logic [COUNT_W-1:0] TF_RESET =
    COUNT_W'((int'(TARGET_RESET) * FIFO_FRAMES) / 100);

  localparam logic [8:0]  HEALTH_PERIOD   = 9'd500;
  localparam logic [10:0] TUNE_PERIOD     = 11'd1500;
  localparam logic [31:0] STREAM_WINDOW   = 32'd500;
  localparam logic [31:0] STANDBY_FLOOR   = 32'd5000;
  localparam logic [COUNT_W-1:0] STREAM_MIN_FRAMES = COUNT_W'(64);
  localparam logic [31:0] EVENT_THRESHOLD = 32'd2;
  localparam logic [6:0]  HEALTH_FLOOR    = 7'd70;
  localparam logic [6:0]  HEALTH_OK_MIN   = 7'd90;
  localparam logic [6:0]  HEALTH_BUSY_MIN = 7'd50;

  localparam logic [1:0] MODE_PUSH  = 2'd0;
  localparam logic [1:0] MODE_POP   = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  localparam logic [1:0] CLASS_OK   = 2'd0;
  localparam logic [1:0] CLASS_BUSY = 2'd1;
  localparam logic [1:0] CLASS_RISK = 2'd2;

  localparam logic [1:0] SRC_STANDBY_MODE = 2'd1;

  localparam logic CFG_SOURCE_MODE     = 1'b0;
  localparam logic CFG_STANDBY_TIMEOUT = 1'b1;

  typedef struct packed {
    logic [1:0]          mode;
    logic signed [15:0]  sample_left;
    logic signed [15:0]  sample_right;
    logic                mono;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0]  out_left;
    logic signed [15:0]  out_right;
    logic                out_valid;
    logic [6:0]          fill_percent;
    logic [11:0]         latency_ms;
    logic [6:0]          health_percent;
    logic [1:0]          health_class;
    logic [6:0]          target_fill;
    logic                streaming;
    logic                standby;
    logic [31:0]         underrun_total;
    logic [31:0]         overrun_total;
  } out_word_t;

endpackage

### rtl/stereo_audio_fifo_health_monitor_core.sv
// A word on start appears on result_valid_o/out_word_o in the cycle after it is accepted.
// Throughput: one word per cycle; busy is never raised. A pop reads the frame
// memory through its single registered read port in the accept cycle.
// Reset: all counters, pointers and timers clear, target fill returns to 25,
// health class to at-risk. Frame memory contents are not cleared.
module stereo_audio_fifo_health_monitor_core import safhm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  in_word_t    in_word_i,
  output logic        result_valid_o,
  output out_word_t   out_word_o,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [31:0] cfg_wdata_i
);

  logic [31:0] mem [FIFO_FRAMES];
  logic [31:0] rd_data_q;

  logic               accept;
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [31:0]        ms_input_q, ms_input_d;
  logic [8:0]         ms_health_q, ms_health_d;
  logic [10:0]        ms_tune_q, ms_tune_d;
  logic [6:0]         target_q, target_d;
  logic [6:0]         health_q, health_d;
  logic [1:0]         level_q, level_d;
  logic [31:0]        under_q, under_d, over_q, over_d;
  logic [31:0]        usnap_q, usnap_d, osnap_q, osnap_d;
  logic [1:0]         src_mode_q;
  logic [31:0]        stby_limit_q;
  logic [COUNT_W-1:0] tf_q;
  logic               res_valid_q, pop_ok_q;

  logic               push_ok, pop_ok;
  logic [31:0]        wr_word;
  logic [6:0]         target_tuned;
  logic [31:0]        ms_input_inc;

  logic [COUNT_W+TF_MULT_W+6:0] tf_prod;
  logic [COUNT_W-1:0]           diff;
  logic [COUNT_W+6:0]           loss_prod;
  logic [7:0]                   loss;
  logic [6:0]                   h_raw, h_eval;
  logic                         strm_new;
  logic [31:0]                  du, dov;

  logic [COUNT_W+6:0]            fill_prod;
  logic [COUNT_W+LAT_MULT_W-1:0] lat_prod;
  logic                          strm_out;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign push_ok = accept && (in_word_i.mode == MODE_PUSH) &&
                   (count_q < COUNT_W'(FIFO_FRAMES));
  assign pop_ok  = accept && (in_word_i.mode == MODE_POP) && (count_q != '0);
  assign wr_word = {in_word_i.mono ? in_word_i.sample_left : in_word_i.sample_right,
                    in_word_i.sample_left};

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem[wr_ptr_q] <= wr_word;
    end
    rd_data_q <= mem[rd_ptr_q];
  end

  // target frames is registered from the target and follows it in the next cycle; used only on health ticks
  assign tf_prod = (COUNT_W+TF_MULT_W+7)'(target_q) * (COUNT_W+TF_MULT_W+7)'(TF_MULT);

  assign ms_input_inc = (ms_input_q != '1) ? ms_input_q + 32'd1 : ms_input_q;

  assign diff      = (count_q > tf_q) ? count_q - tf_q : tf_q - count_q;
  assign loss_prod = (COUNT_W+7)'(diff) * (COUNT_W+7)'(100);
  assign loss      = 8'(loss_prod / HALF_FRAMES);
  assign h_raw     = (loss >= 8'd100) ? 7'd0 : 7'(8'd100 - loss);
  assign strm_new  = (ms_input_inc < STREAM_WINDOW) && (count_q > STREAM_MIN_FRAMES);
  assign h_eval    = (strm_new && h_raw < HEALTH_FLOOR) ? HEALTH_FLOOR : h_raw;

  assign du  = under_q - usnap_q;
  assign dov = over_q - osnap_q;

  always_comb begin
    target_tuned = target_q;
    if (du > EVENT_THRESHOLD && target_q < TARGET_RISE_LIMIT) begin
      target_tuned = target_q + TARGET_STEP;
    end else if (dov > EVENT_THRESHOLD && target_q > TARGET_FALL_LIMIT) begin
      target_tuned = target_q - TARGET_STEP;
    end
    if (target_tuned < TARGET_MIN) begin
      target_tuned = TARGET_MIN;
    end
    if (target_tuned > TARGET_MAX) begin
      target_tuned = TARGET_MAX;
    end
  end

  always_comb begin
    wr_ptr_d    = wr_ptr_q;
    rd_ptr_d    = rd_ptr_q;
    count_d     = count_q;
    ms_input_d  = ms_input_q;
    ms_health_d = ms_health_q;
    ms_tune_d   = ms_tune_q;
    target_d    = target_q;
    health_d    = health_q;
    level_d     = level_q;
    under_d     = under_q;
    over_d      = over_q;
    usnap_d     = usnap_q;
    osnap_d     = osnap_q;
    if (accept) begin
      case (in_word_i.mode)
        MODE_PUSH: begin
          if (push_ok) begin
            wr_ptr_d = (wr_ptr_q == PTR_W'(FIFO_FRAMES - 1)) ? '0 : wr_ptr_q + 1'b1;
            count_d  = count_q + 1'b1;
          end else begin
            over_d = over_q + 32'd1;
          end
          ms_input_d = '0;
        end
        MODE_POP: begin
          if (pop_ok) begin
            rd_ptr_d = (rd_ptr_q == PTR_W'(FIFO_FRAMES - 1)) ? '0 : rd_ptr_q + 1'b1;
            count_d  = count_q - 1'b1;
          end else begin
            under_d = under_q + 32'd1;
          end
        end
        MODE_TICK: begin
          ms_input_d  = ms_input_inc;
          ms_health_d = ms_health_q + 9'd1;
          ms_tune_d   = ms_tune_q + 11'd1;
          if (ms_health_d >= HEALTH_PERIOD) begin
            health_d    = h_eval;
            level_d     = (h_eval >= HEALTH_OK_MIN)   ? CLASS_OK :
                          (h_eval >= HEALTH_BUSY_MIN) ? CLASS_BUSY : CLASS_RISK;
            ms_health_d = '0;
          end
          if (ms_tune_d >= TUNE_PERIOD) begin
            target_d  = target_tuned;
            usnap_d   = under_q;
            osnap_d   = over_q;
            ms_tune_d = '0;
          end
        end
        MODE_CLEAR: begin
          under_d = '0;
          over_d  = '0;
          usnap_d = '0;
          osnap_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q     <= '0;
      rd_ptr_q     <= '0;
      count_q      <= '0;
      ms_input_q   <= '0;
      ms_health_q  <= '0;
      ms_tune_q    <= '0;
      target_q     <= TARGET_RESET;
      health_q     <= '0;
      level_q      <= CLASS_RISK;
      under_q      <= '0;
      over_q       <= '0;
      usnap_q      <= '0;
      osnap_q      <= '0;
      src_mode_q   <= '0;
      stby_limit_q <= STANDBY_FLOOR;
      tf_q         <= TF_RESET;
      res_valid_q  <= 1'b0;
      pop_ok_q     <= 1'b0;
    end else begin
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      count_q     <= count_d;
      ms_input_q  <= ms_input_d;
      ms_health_q <= ms_health_d;
      ms_tune_q   <= ms_tune_d;
      target_q    <= target_d;
      health_q    <= health_d;
      level_q     <= level_d;
      under_q     <= under_d;
      over_q      <= over_d;
      usnap_q     <= usnap_d;
      osnap_q     <= osnap_d;
      tf_q        <= COUNT_W'(tf_prod >> TF_SHIFT);
      res_valid_q <= accept;
      pop_ok_q    <= pop_ok;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_SOURCE_MODE: begin
            src_mode_q <= cfg_wdata_i[1:0];
          end
          CFG_STANDBY_TIMEOUT: begin
            stby_limit_q <= (cfg_wdata_i < STANDBY_FLOOR) ? STANDBY_FLOOR : cfg_wdata_i;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign fill_prod = (COUNT_W+7)'(count_q) * (COUNT_W+7)'(100);
  assign lat_prod  = (COUNT_W+LAT_MULT_W)'(count_q) * (COUNT_W+LAT_MULT_W)'(LAT_MULT);
  assign strm_out  = (ms_input_q < STREAM_WINDOW) && (count_q > STREAM_MIN_FRAMES);

  assign result_valid_o = res_valid_q;

  always_comb begin
    out_word_o                = '0;
    out_word_o.out_left       = pop_ok_q ? rd_data_q[15:0] : 16'sd0;
    out_word_o.out_right      = pop_ok_q ? rd_data_q[31:16] : 16'sd0;
    out_word_o.out_valid      = pop_ok_q;
    out_word_o.fill_percent   = 7'(fill_prod / FIFO_FRAMES);
    out_word_o.latency_ms     = 12'(lat_prod >> LAT_SHIFT);
    out_word_o.health_percent = health_q;
    out_word_o.health_class   = level_q;
    out_word_o.target_fill    = target_q;
    out_word_o.streaming      = strm_out;
    out_word_o.standby        = (src_mode_q == SRC_STANDBY_MODE) && !strm_out &&
                                (ms_input_q >= stby_limit_q);
    out_word_o.underrun_total = under_q;
    out_word_o.overrun_total  = over_q;
  end

endmodule

### rtl/safhm_checker.sv
module safhm_checker import safhm_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start,
  input logic      busy,
  input in_word_t  in_word_i,
  input logic      result_valid_o,
  input out_word_t out_word_o
);

  // every accepted word yields exactly one result, in the next cycle
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> result_valid_o)
    else $error("accepted word produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |=> !result_valid_o)
    else $error("result without accepted word");

  a_valid_only_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && in_word_i.mode != MODE_POP) |=>
      (!out_word_o.out_valid && out_word_o.out_left == 16'sd0 &&
       out_word_o.out_right == 16'sd0))
    else $error("non-pop word returned frame data");

  a_class_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |->
      ((out_word_o.health_percent >= HEALTH_OK_MIN) == (out_word_o.health_class == CLASS_OK)) &&
      (out_word_o.target_fill >= TARGET_MIN) && (out_word_o.target_fill <= TARGET_MAX))
    else $error("health class or target fill out of line");

endmodule

bind stereo_audio_fifo_health_monitor_core safhm_checker u_safhm_checker (.*);
